FILE: rtl/core/tlfg_pkg.sv
// Shared widths, latencies and defaults of the triangle gradient pipeline.
package tlfg_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int LIMB_W = 32;
    localparam int MUL_LAT = 4;
    localparam int IN_W = 32;
    localparam int DIFF_W = IN_W + 1;
    localparam int CRS_W = 2 * DIFF_W + 1;
    localparam int SQ_W = 2 * CRS_W;
    localparam int DEN_W = SQ_W + 2;
    localparam int UV_W = DIFF_W + CRS_W + 1;
    localparam int NP_W = DIFF_W + UV_W;
    localparam int NS_W = NP_W + 1;
    localparam int OUT_W = 32;
    localparam int QUOT_W = OUT_W + 1;
    localparam int DIV_LAT = QUOT_W + 2;
endpackage

FILE: rtl/core/tlfg_mul.sv
// Signed multiplier pipelined in four stages: magnitudes, limb products, row sums, total.
module tlfg_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    i_clk,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int LW = tlfg_pkg::LIMB_W;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int PW = WA + WB;

    logic [WA-1:0]      w_ma;
    logic [WB-1:0]      w_mb;
    logic [NA*LW-1:0]   r_ma;
    logic [NB*LW-1:0]   r_mb;
    logic               r_neg1;
    logic               r_neg2;
    logic               r_neg3;
    logic [2*LW-1:0]    r_pp [NA][NB];
    logic [PW-1:0]      n_row [NA];
    logic [PW-1:0]      r_row [NA];
    logic [PW-1:0]      n_sum;
    logic signed [PW-1:0] r_p;

    assign w_ma = i_a[WA-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign w_mb = i_b[WB-1] ? $unsigned(-i_b) : $unsigned(i_b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (j * LW));
            end
        end
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            n_sum = n_sum + (r_row[i] << (i * LW));
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma   <= (NA*LW)'(w_ma);
        r_mb   <= (NB*LW)'(w_mb);
        r_neg1 <= i_a[WA-1] ^ i_b[WB-1];
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                r_pp[i][j] <= (2*LW)'(r_ma[i*LW +: LW]) * (2*LW)'(r_mb[j*LW +: LW]);
            end
        end
        r_neg2 <= r_neg1;
        r_row  <= n_row;
        r_neg3 <= r_neg2;
        r_p    <= r_neg3 ? -$signed(n_sum) : $signed(n_sum);
    end

    assign o_p = r_p;
endmodule

FILE: rtl/core/tlfg_div.sv
// Pipelined restoring divider with rounding to nearest and 32-bit saturation.
module tlfg_div #(
    parameter int NUMW = 152,
    parameter int DENW = 136
) (
    input  logic                                  i_clk,
    input  logic [NUMW-1:0]                       i_num,
    input  logic [DENW-1:0]                       i_den,
    input  logic                                  i_neg,
    output logic signed [tlfg_pkg::OUT_W-1:0]     o_q
);
    localparam int QB = tlfg_pkg::QUOT_W;
    localparam int OW = tlfg_pkg::OUT_W;
    localparam int CW = (NUMW > DENW + QB) ? NUMW : DENW + QB;
    localparam logic [QB-1:0] NEG_LIM = QB'(1) << (OW - 1);
    localparam logic [QB-1:0] POS_LIM = NEG_LIM - QB'(1);
    localparam logic [OW-1:0] Q_MIN = {1'b1, {(OW-1){1'b0}}};
    localparam logic [OW-1:0] Q_MAX = {1'b0, {(OW-1){1'b1}}};

    logic [DENW-1:0] r_rem [QB+1];
    logic [DENW-1:0] r_den [QB+1];
    logic [QB-1:0]   r_low [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic            r_neg [QB+1];
    logic            r_sat [QB+1];
    logic [QB:0]     w_rsum;
    logic [QB-1:0]   w_qr;
    logic [OW-1:0]   n_q;
    logic [OW-1:0]   r_q_out;

    always_ff @(posedge i_clk) begin
        r_sat[0] <= CW'(i_num) >= (CW'(i_den) << QB);
        r_rem[0] <= DENW'(CW'(i_num) >> QB);
        r_low[0] <= i_num[QB-1:0];
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_neg[0] <= i_neg;
    end

    for (genvar s = 1; s <= QB; s++) begin : g_step
        localparam int B = QB - s;
        logic [DENW:0] w_r2;
        logic          w_ge;
        assign w_r2 = {r_rem[s-1], r_low[s-1][B]};
        assign w_ge = w_r2 >= {1'b0, r_den[s-1]};
        always_ff @(posedge i_clk) begin
            r_rem[s] <= w_ge ? DENW'(w_r2 - {1'b0, r_den[s-1]}) : DENW'(w_r2);
            r_q[s]   <= r_q[s-1] | (QB'(w_ge) << B);
            r_low[s] <= r_low[s-1];
            r_den[s] <= r_den[s-1];
            r_neg[s] <= r_neg[s-1];
            r_sat[s] <= r_sat[s-1];
        end
    end

    assign w_rsum = {1'b0, r_q[QB]} + (QB+1)'(1);
    assign w_qr   = w_rsum[QB:1];

    always_comb begin
        priority if (r_sat[QB]) begin
            n_q = r_neg[QB] ? Q_MIN : Q_MAX;
        end else if (r_neg[QB]) begin
            n_q = (w_qr > NEG_LIM) ? Q_MIN : OW'(-w_qr);
        end else begin
            n_q = (w_qr > POS_LIM) ? Q_MAX : w_qr[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_out <= n_q;
    end

    assign o_q = $signed(r_q_out);
endmodule

FILE: rtl/core/triangle_linear_field_gradient_top.sv
// Top level of the streaming linear-triangle field gradient pipeline.
//
//  Channel   Handshake              Payload
//  -------   --------------------   ---------------------------------------------
//  input     start, busy (0)        i_p1_*, i_p2_*, i_p3_*, i_val_1..3
//  result    o_valid (strobe)       o_grad_x, o_grad_y, o_grad_z, o_degenerate
//
// One transaction is taken every cycle; busy is always low.
// Each result passes through three chained multiplier stages and the 33-step
// divider pipeline.
// Synchronous reset clears only the valid bits; data stages need no reset.
// The receiver cannot stall, so nothing ever holds in the pipeline.
module triangle_linear_field_gradient_top #(
    parameter int FRAC_BITS = tlfg_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p1_z,
    input  logic signed [31:0] i_p2_x,
    input  logic signed [31:0] i_p2_y,
    input  logic signed [31:0] i_p2_z,
    input  logic signed [31:0] i_p3_x,
    input  logic signed [31:0] i_p3_y,
    input  logic signed [31:0] i_p3_z,
    input  logic signed [31:0] i_val_1,
    input  logic signed [31:0] i_val_2,
    input  logic signed [31:0] i_val_3,
    output logic               o_valid,
    output logic signed [31:0] o_grad_x,
    output logic signed [31:0] o_grad_y,
    output logic signed [31:0] o_grad_z,
    output logic               o_degenerate
);
    localparam int L = tlfg_pkg::MUL_LAT;
    localparam int DW = tlfg_pkg::DIFF_W;
    localparam int CRW = tlfg_pkg::CRS_W;
    localparam int SQW = tlfg_pkg::SQ_W;
    localparam int DENW = tlfg_pkg::DEN_W;
    localparam int UVW = tlfg_pkg::UV_W;
    localparam int NPW = tlfg_pkg::NP_W;
    localparam int NSW = tlfg_pkg::NS_W;
    localparam int OW = tlfg_pkg::OUT_W;
    localparam int DLAT = tlfg_pkg::DIV_LAT;
    localparam int NUMW = NSW + FRAC_BITS + 1;
    localparam int T_DIV = 3 * L + 5;
    localparam int TOT = T_DIV + DLAT + 1;
    localparam int D_DLY = L + 1;
    localparam int F_DLY = 2 * L + 2;
    localparam int N_DLY = L + 1;

    logic signed [31:0]     w_p1 [3];
    logic signed [31:0]     w_p2 [3];
    logic signed [31:0]     w_p3 [3];
    logic [TOT:1]           r_vld;
    logic [TOT:1]           n_vld;

    logic signed [DW-1:0]   r_d1 [3];
    logic signed [DW-1:0]   r_d2 [3];
    logic signed [DW-1:0]   r_df1;
    logic signed [DW-1:0]   r_df2;
    logic signed [DW-1:0]   r_d1d [D_DLY][3];
    logic signed [DW-1:0]   r_d2d [D_DLY][3];
    logic signed [DW-1:0]   r_df1d [F_DLY];
    logic signed [DW-1:0]   r_df2d [F_DLY];

    logic signed [2*DW-1:0] w_cp0 [3];
    logic signed [2*DW-1:0] w_cp1 [3];
    logic signed [CRW-1:0]  r_c [3];
    logic signed [SQW-1:0]  w_sq [3];
    logic signed [DW+CRW-1:0] w_u0 [3];
    logic signed [DW+CRW-1:0] w_u1 [3];
    logic signed [DW+CRW-1:0] w_v0 [3];
    logic signed [DW+CRW-1:0] w_v1 [3];
    logic signed [DENW-1:0] r_den;
    logic signed [UVW-1:0]  r_u [3];
    logic signed [UVW-1:0]  r_v [3];
    logic signed [DENW-1:0] r_dend [N_DLY];
    logic signed [NPW-1:0]  w_n0 [3];
    logic signed [NPW-1:0]  w_n1 [3];
    logic signed [NSW-1:0]  r_n [3];

    logic [NSW-1:0]         w_nmag [3];
    logic [NUMW-1:0]        r_num [3];
    logic                   r_nneg [3];
    logic [DENW-1:0]        r_dn;
    logic                   r_deg;
    logic                   r_degd [DLAT];
    logic signed [OW-1:0]   w_q [3];
    logic signed [OW-1:0]   r_g [3];
    logic                   r_odeg;

    assign w_p1[0] = i_p1_x;
    assign w_p1[1] = i_p1_y;
    assign w_p1[2] = i_p1_z;
    assign w_p2[0] = i_p2_x;
    assign w_p2[1] = i_p2_y;
    assign w_p2[2] = i_p2_z;
    assign w_p3[0] = i_p3_x;
    assign w_p3[1] = i_p3_y;
    assign w_p3[2] = i_p3_z;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[TOT-1:1], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_d1[k] <= DW'(w_p2[k]) - DW'(w_p1[k]);
            r_d2[k] <= DW'(w_p3[k]) - DW'(w_p1[k]);
        end
        r_df1 <= DW'(i_val_2) - DW'(i_val_1);
        r_df2 <= DW'(i_val_3) - DW'(i_val_1);
        r_d1d[0]  <= r_d1;
        r_d2d[0]  <= r_d2;
        r_df1d[0] <= r_df1;
        r_df2d[0] <= r_df2;
        for (int i = 1; i < D_DLY; i++) begin
            r_d1d[i] <= r_d1d[i-1];
            r_d2d[i] <= r_d2d[i-1];
        end
        for (int i = 1; i < F_DLY; i++) begin
            r_df1d[i] <= r_df1d[i-1];
            r_df2d[i] <= r_df2d[i-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_c[k] <= CRW'(w_cp0[k]) - CRW'(w_cp1[k]);
            r_u[k] <= UVW'(w_u0[k]) - UVW'(w_u1[k]);
            r_v[k] <= UVW'(w_v0[k]) - UVW'(w_v1[k]);
            r_n[k] <= NSW'(w_n0[k]) + NSW'(w_n1[k]);
        end
        r_den     <= DENW'(w_sq[0]) + DENW'(w_sq[1]) + DENW'(w_sq[2]);
        r_dend[0] <= r_den;
        for (int i = 1; i < N_DLY; i++) begin
            r_dend[i] <= r_dend[i-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_nneg[k] <= r_n[k][NSW-1];
            r_num[k]  <= NUMW'(w_nmag[k]) << (FRAC_BITS + 1);
        end
        r_dn      <= $unsigned(r_dend[N_DLY-1]);
        r_deg     <= r_dend[N_DLY-1] == '0;
        r_degd[0] <= r_deg;
        for (int i = 1; i < DLAT; i++) begin
            r_degd[i] <= r_degd[i-1];
        end
        for (int k = 0; k < 3; k++) begin
            r_g[k] <= r_degd[DLAT-1] ? '0 : w_q[k];
        end
        r_odeg <= r_vld[TOT-1] & r_degd[DLAT-1];
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;

        assign w_nmag[k] = r_n[k][NSW-1] ? $unsigned(-r_n[k]) : $unsigned(r_n[k]);

        tlfg_mul #(.WA(DW), .WB(DW)) u_c0 (
            .i_clk (i_clk), .i_a (r_d1[I1]), .i_b (r_d2[I2]), .o_p (w_cp0[k])
        );
        tlfg_mul #(.WA(DW), .WB(DW)) u_c1 (
            .i_clk (i_clk), .i_a (r_d1[I2]), .i_b (r_d2[I1]), .o_p (w_cp1[k])
        );
        tlfg_mul #(.WA(CRW), .WB(CRW)) u_sq (
            .i_clk (i_clk), .i_a (r_c[k]), .i_b (r_c[k]), .o_p (w_sq[k])
        );
        tlfg_mul #(.WA(DW), .WB(CRW)) u_u0 (
            .i_clk (i_clk), .i_a (r_d2d[D_DLY-1][I1]), .i_b (r_c[I2]), .o_p (w_u0[k])
        );
        tlfg_mul #(.WA(DW), .WB(CRW)) u_u1 (
            .i_clk (i_clk), .i_a (r_d2d[D_DLY-1][I2]), .i_b (r_c[I1]), .o_p (w_u1[k])
        );
        tlfg_mul #(.WA(DW), .WB(CRW)) u_v0 (
            .i_clk (i_clk), .i_a (r_d1d[D_DLY-1][I2]), .i_b (r_c[I1]), .o_p (w_v0[k])
        );
        tlfg_mul #(.WA(DW), .WB(CRW)) u_v1 (
            .i_clk (i_clk), .i_a (r_d1d[D_DLY-1][I1]), .i_b (r_c[I2]), .o_p (w_v1[k])
        );
        tlfg_mul #(.WA(DW), .WB(UVW)) u_n0 (
            .i_clk (i_clk), .i_a (r_df1d[F_DLY-1]), .i_b (r_u[k]), .o_p (w_n0[k])
        );
        tlfg_mul #(.WA(DW), .WB(UVW)) u_n1 (
            .i_clk (i_clk), .i_a (r_df2d[F_DLY-1]), .i_b (r_v[k]), .o_p (w_n1[k])
        );
        tlfg_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
            .i_clk (i_clk),
            .i_num (r_num[k]),
            .i_den (r_dn),
            .i_neg (r_nneg[k]),
            .o_q   (w_q[k])
        );
    end

    assign o_valid      = r_vld[TOT];
    assign o_grad_x     = r_g[0];
    assign o_grad_y     = r_g[1];
    assign o_grad_z     = r_g[2];
    assign o_degenerate = r_odeg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_grad_x == '0 && o_grad_y == '0 && o_grad_z == '0)
        else $error("Degenerate transaction carries a non-zero gradient.");

    a_deg_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_degenerate |-> o_valid)
        else $error("Degenerate flag raised without a result strobe.");

    a_zero_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[T_DIV] && r_num[0] == '0 |-> ##(DLAT + 1) (o_valid && o_grad_x == '0))
        else $error("Zero numerator did not give a zero x gradient.");
endmodule

FILE: verif/triangle_linear_field_gradient_top_tb.sv
// Self-checking testbench for the triangle linear field gradient block.
`timescale 1ns / 100ps

module triangle_linear_field_gradient_top_tb;
    localparam int FRAC = tlfg_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM = 1600;
    localparam int DRAIN_CYCLES = 80;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [31:0] tri_t [12];
    typedef struct packed {
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic               degen;
    } grad_t;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [31:0] fld [12];
    logic o_valid;
    logic signed [31:0] o_grad_x, o_grad_y, o_grad_z;
    logic o_degenerate;

    grad_t gradients_due[$];
    int    n_errors;

    tri_t  dir_in [$];
    logic  dir_typed [$];
    grad_t dir_want [$];

    triangle_linear_field_gradient_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_p1_x(fld[0]), .i_p1_y(fld[1]), .i_p1_z(fld[2]),
        .i_p2_x(fld[3]), .i_p2_y(fld[4]), .i_p2_z(fld[5]),
        .i_p3_x(fld[6]), .i_p3_y(fld[7]), .i_p3_z(fld[8]),
        .i_val_1(fld[9]), .i_val_2(fld[10]), .i_val_3(fld[11]),
        .o_valid(o_valid), .o_grad_x(o_grad_x), .o_grad_y(o_grad_y),
        .o_grad_z(o_grad_z), .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic add_row(input tri_t t, input logic typed, input grad_t want);
        dir_in.insert(dir_in.size(), t);
        dir_typed.insert(dir_typed.size(), typed);
        dir_want.insert(dir_want.size(), want);
    endtask

    function automatic void cross3(input wide_t a [3], input wide_t b [3],
                                   output wide_t r [3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic signed [31:0] round_div_sat(input wide_t num, input wide_t den);
        logic [255:0] m, q, r;
        logic neg;
        neg = num < 0;
        m = neg ? -num : num;
        q = m / den;
        r = m % den;
        if ((r << 1) >= den) q = q + 1;
        if (neg) begin
            if (q > 256'h8000_0000) return 32'sh8000_0000;
            return -q[31:0];
        end
        if (q > 256'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic grad_t field_gradient(input tri_t t);
        wide_t e1 [3], e2 [3], c [3], u [3], v [3];
        wide_t base, den, df1, df2, num [3];
        grad_t g;
        for (int k = 0; k < 3; k++) begin
            base = t[k];
            e1[k] = t[3 + k];
            e2[k] = t[6 + k];
            e1[k] = e1[k] - base;
            e2[k] = e2[k] - base;
        end
        base = t[9];
        df1 = t[10];
        df2 = t[11];
        df1 = df1 - base;
        df2 = df2 - base;
        cross3(e1, e2, c);
        den = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        g = '0;
        if (den == 0) begin
            g.degen = 1'b1;
            return g;
        end
        cross3(e2, c, u);
        cross3(c, e1, v);
        for (int k = 0; k < 3; k++) num[k] = (df1 * u[k] + df2 * v[k]) <<< FRAC;
        g.gx = round_div_sat(num[0], den);
        g.gy = round_div_sat(num[1], den);
        g.gz = round_div_sat(num[2], den);
        return g;
    endfunction

    always @(posedge i_clk) begin
        grad_t want;
        if (i_rst_n && o_valid) begin
            if (gradients_due.size() == 0) begin
                $display("ERROR %0t: result with no transaction outstanding", $realtime);
                n_errors++;
            end else begin
                want = gradients_due.pop_front();
                if (o_grad_x !== want.gx) report_mismatch("grad_x", o_grad_x, want.gx);
                if (o_grad_y !== want.gy) report_mismatch("grad_y", o_grad_y, want.gy);
                if (o_grad_z !== want.gz) report_mismatch("grad_z", o_grad_z, want.gz);
                if (o_degenerate !== want.degen)
                    report_mismatch("degenerate", o_degenerate, want.degen);
            end
        end
    end

    task automatic send_triangle(input tri_t t, input grad_t want);
        @(negedge i_clk);
        start <= 1'b1;
        for (int k = 0; k < 12; k++) fld[k] <= t[k];
        do @(posedge i_clk); while (busy !== 1'b0);
        gradients_due = {gradients_due, want};
    endtask

    task automatic idle_gap();
        int n, r;
        r = $urandom_range(99);
        n = (r < 65) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] rnd_full();
        return $urandom();
    endfunction

    function automatic logic signed [31:0] rnd_span(input int bits);
        logic signed [31:0] x;
        x = $urandom();
        return x >>> (32 - bits);
    endfunction

    function automatic tri_t random_triangle();
        tri_t t;
        int mode, k0, bits;
        logic signed [31:0] s;
        mode = $urandom_range(99);
        bits = $urandom_range(28, 4);
        for (int k = 0; k < 12; k++) t[k] = rnd_span(bits);
        if (mode < 15) begin
            for (int k = 0; k < 12; k++) t[k] = rnd_full();
        end else if (mode < 27) begin
            // Collinear vertices: the third lies on the line through the first two.
            k0 = $urandom_range(3) - 1;
            for (int k = 0; k < 3; k++) begin
                t[k] = rnd_span(20);
                t[3 + k] = t[k] + rnd_span(8);
                t[6 + k] = t[k] + k0 * (t[3 + k] - t[k]);
            end
        end else if (mode < 33) begin
            for (int k = 0; k < 3; k++) t[3 + k] = t[k];
        end else if (mode < 40) begin
            // Tiny triangle with large field values drives the outputs into saturation.
            for (int k = 0; k < 3; k++) begin
                s = rnd_span(2);
                t[3 + k] = t[k] + s;
                t[6 + k] = t[k] + rnd_span(2);
            end
            for (int k = 9; k < 12; k++) t[k] = rnd_full();
        end
        return t;
    endfunction

    initial begin
        tri_t  t;
        grad_t g;
        localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
        localparam logic signed [31:0] MINV = 32'sh8000_0000;
        localparam logic signed [31:0] ONE = 32'sh0001_0000;

        n_errors = 0;
        start = 1'b0;
        for (int k = 0; k < 12; k++) fld[k] = '0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        t = '{default: 0};
        add_row(t, 1'b1, {96'b0, 1'b1});
        t = '{default: MAXV};
        add_row(t, 1'b1, {96'b0, 1'b1});
        t = '{default: MINV};
        add_row(t, 1'b1, {96'b0, 1'b1});
        t = '{MINV, MINV, MINV, 0, 0, 0, MAXV, MAXV, MAXV, 5, 6, 7};
        add_row(t, 1'b0, '0);
        t = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0};
        add_row(t, 1'b1, {ONE, 32'd0, 32'd0, 1'b0});
        t = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
        add_row(t, 1'b1, {32'd0, ONE, 32'd0, 1'b0});
        t = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, MAXV, 0};
        add_row(t, 1'b1, {MAXV, 32'd0, 32'd0, 1'b0});
        t = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, MINV, 0};
        add_row(t, 1'b1, {MINV, 32'd0, 32'd0, 1'b0});
        t = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MINV, MINV, MAXV, MINV};
        add_row(t, 1'b0, '0);
        t = '{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MAXV, MAXV, MINV, MAXV};
        add_row(t, 1'b0, '0);
        t = '{0, 0, 0, 0, 0, ONE, 0, ONE, 0, 3, -ONE, 7 * ONE};
        add_row(t, 1'b0, '0);
        t = '{ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE, 1, 2, 3};
        add_row(t, 1'b1, {96'b0, 1'b1});
        t = '{0, 0, 0, 3, 0, 0, 0, 2, 0, 0, 1, 1};
        add_row(t, 1'b0, '0);
        t = '{-1, -1, -1, MAXV, 0, 0, 0, MAXV, 0, MINV, MAXV, MAXV};
        add_row(t, 1'b0, '0);

        foreach (dir_in[i]) begin
            g = dir_typed[i] ? dir_want[i] : field_gradient(dir_in[i]);
            send_triangle(dir_in[i], g);
            if (i % 4 == 3) idle_gap();
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            t = random_triangle();
            send_triangle(t, field_gradient(t));
            if (i == N_RANDOM / 2) begin
                @(negedge i_clk);
                start <= 1'b0;
                while (gradients_due.size() != 0) @(negedge i_clk);
            end else if (i % 200 < 120) begin
                idle_gap();
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (gradients_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
